// File: hdl/indexed_to_rgba_expand_defines.svh
// assertion helpers used by the unpacker module
`ifndef INDEXED_TO_RGBA_EXPAND_DEFINES_SVH
`define INDEXED_TO_RGBA_EXPAND_DEFINES_SVH

// property checked on every rising edge, switched off while reset is low
`define ITR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent on one edge, consequent on the next
`define ITR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/itr_pkg.sv
`default_nettype none

package itr_pkg;

    localparam int unsigned MAX_WIDTH     = 4096;
    localparam int unsigned PALETTE_DEPTH = 256;

    localparam int unsigned PAL_AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned WIDTH_W    = 13;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned COLOR_W    = 4 * CHAN_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned K_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_MODE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_COLORS_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        OP_PALETTE_WRITE = 1'b0,
        OP_PIXEL         = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_1BPP = 2'd0,
        MODE_2BPP = 2'd1,
        MODE_4BPP = 2'd2,
        MODE_8BPP = 2'd3
    } t_depth_mode;

    localparam t_depth_mode          DEPTH_MODE_RST   = MODE_8BPP;
    localparam logic [WIDTH_W-1:0]   IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [COUNT_W-1:0]   COLORS_COUNT_RST = 9'd256;

    // effective settings after clamping
    typedef struct packed {
        t_depth_mode          mode;
        logic [WIDTH_W-1:0]   width;
        logic [COUNT_W-1:0]   count;
    } t_cfg;

    typedef struct packed {
        logic last_of_run;
        logic row_end;
    } t_pix_meta;

    typedef struct packed {
        t_op               op;
        logic [PIX_W-1:0]  pixel_byte;
        logic [7:0]        entry_index;
        logic [CHAN_W-1:0] entry_red;
        logic [CHAN_W-1:0] entry_green;
        logic [CHAN_W-1:0] entry_blue;
        logic [CHAN_W-1:0] entry_alpha;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_of_run;
        logic              row_end;
    } t_out_item;

endpackage

`default_nettype wire

// File: hdl/itr_ram.sv
`default_nettype none

module itr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old word when the same entry is written on that edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/itr_unpack.sv
`default_nettype none

module itr_unpack (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire itr_pkg::t_cfg                i_cfg,
    input  wire logic                         i_in_valid,
    input  wire itr_pkg::t_in_item            i_in_data,
    output logic                              o_in_ready,
    input  wire logic                         i_issue_ok,
    output logic                              o_rd_en,
    output logic [itr_pkg::PAL_AW-1:0]        o_rd_addr,
    output itr_pkg::t_pix_meta                o_rd_meta
);
    import itr_pkg::*;

    `include "indexed_to_rgba_expand_defines.svh"

    logic               r_busy, n_busy;
    logic [PIX_W-1:0]   r_byte, n_byte;
    logic [K_W-1:0]     r_k, n_k;
    logic [COL_W-1:0]   r_col, n_col;

    logic [PIX_W-1:0]   idx_raw;
    logic [PIX_W-1:0]   idx;
    logic [PIX_W-1:0]   byte_shift;
    logic [K_W-1:0]     last_k;
    logic [COL_W-1:0]   col_cur;
    logic [WIDTH_W-1:0] col_inc;
    logic               rend;
    logic               last;
    logic               issue;
    logic               issue_last;
    logic               in_fire;
    logic               pix_fire;

    // leftmost pixel sits in the top bits, the byte shifts left per pixel
    always_comb begin
        unique case (i_cfg.mode)
            MODE_1BPP: begin
                idx_raw    = {7'd0, r_byte[7]};
                byte_shift = {r_byte[6:0], 1'b0};
                last_k     = 3'd7;
            end
            MODE_2BPP: begin
                idx_raw    = {6'd0, r_byte[7:6]};
                byte_shift = {r_byte[5:0], 2'b00};
                last_k     = 3'd3;
            end
            MODE_4BPP: begin
                idx_raw    = {4'd0, r_byte[7:4]};
                byte_shift = {r_byte[3:0], 4'h0};
                last_k     = 3'd1;
            end
            MODE_8BPP: begin
                idx_raw    = r_byte;
                byte_shift = '0;
                last_k     = 3'd0;
            end
        endcase
    end

    always_comb begin
        idx       = ({1'b0, idx_raw} < i_cfg.count) ? idx_raw : '0;
        o_rd_addr = idx[PAL_AW-1:0];

        // a column left beyond a lowered width restarts the row
        col_cur   = (WIDTH_W'(r_col) >= i_cfg.width) ? '0 : r_col;
        col_inc   = WIDTH_W'(col_cur) + WIDTH_W'(1);
        rend      = (col_inc >= i_cfg.width);
        last      = rend || (r_k == last_k);

        issue      = r_busy && i_issue_ok;
        issue_last = issue && last;
        o_in_ready = !r_busy || issue_last;
        o_rd_en    = issue;
        o_rd_meta  = '{last_of_run: last, row_end: rend};

        in_fire  = i_in_valid && o_in_ready;
        pix_fire = in_fire && (i_in_data.op == OP_PIXEL);
    end

    always_comb begin
        priority if (pix_fire) begin
            n_busy = 1'b1;
            n_byte = i_in_data.pixel_byte;
            n_k    = '0;
        end else if (issue) begin
            n_busy = !last;
            n_byte = byte_shift;
            n_k    = r_k + K_W'(1);
        end else begin
            n_busy = r_busy;
            n_byte = r_byte;
            n_k    = r_k;
        end
        n_col = issue ? (rend ? '0 : col_inc[COL_W-1:0]) : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_col  <= '0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
            r_col  <= n_col;
        end
        r_byte <= n_byte;
    end

    `ITR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, r_busy && !i_issue_ok,
        r_busy && $stable(r_byte) && $stable(r_k), "byte changed while stalled")
    `ITR_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, issue && !last,
        r_busy && (r_k == K_W'($past(r_k) + K_W'(1))), "run ended early")
    `ITR_ASSERT_NEXT(a_pixel_load, i_clk, i_rst_n, pix_fire,
        r_busy && (r_k == '0), "pixel byte not loaded")
    `ITR_ASSERT(a_col_on_row_end, i_clk, i_rst_n, !(issue && rend) || (n_col == '0),
        "column not cleared at row end")

endmodule

`default_nettype wire

// File: hdl/itr_out.sv
`default_nettype none

module itr_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_rd_en,
    input  wire itr_pkg::t_pix_meta           i_rd_meta,
    input  wire logic [itr_pkg::COLOR_W-1:0]  i_rd_data,
    output logic                              o_issue_ok,
    output logic                              o_out_valid,
    output itr_pkg::t_out_item                o_out_data,
    input  wire logic                         i_out_ready
);
    import itr_pkg::*;

    logic       r_s1_valid, n_s1_valid;
    t_pix_meta  r_s1_meta, n_s1_meta;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;
    logic       s1_adv;

    // ram data waits in the ram's own read register while s1 is held
    always_comb begin
        s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
        o_issue_ok = !r_s1_valid || s1_adv;

        n_s1_valid = i_rd_en ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
        n_s1_meta  = i_rd_en ? i_rd_meta : r_s1_meta;

        n_out_valid = s1_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        if (s1_adv) begin
            n_out = '{red:         i_rd_data[CHAN_W-1:0],
                      green:       i_rd_data[2*CHAN_W-1:CHAN_W],
                      blue:        i_rd_data[3*CHAN_W-1:2*CHAN_W],
                      alpha:       i_rd_data[4*CHAN_W-1:3*CHAN_W],
                      last_of_run: r_s1_meta.last_of_run,
                      row_end:     r_s1_meta.row_end};
        end else begin
            n_out = r_out;
        end

        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        r_s1_meta <= n_s1_meta;
        r_out     <= n_out;
    end

endmodule

`default_nettype wire

// File: hdl/indexed_to_rgba_expand.sv
// palette-indexed to rgba32 pixel expander
// input channel (i_in_valid / o_in_ready, payload i_in_data): op selects a palette
// write or a packed pixel byte at 1, 2, 4 or 8 bits per pixel, leftmost pixel in
// the top bits. output channel (o_out_valid / i_out_ready, payload o_out_data):
// one rgba pixel per item, flagged last_of_run on the final pixel of a byte and
// row_end on the final pixel of a row; a byte never crosses a row end.
// config port: i_cfg_we with i_cfg_index 0 depth mode, 1 image width, 2 colour
// count; write only while the block is idle.
// path: byte register, palette read register, output register. throughput: one
// pixel per cycle unless stalled, set by the single palette read port; the next
// byte or palette write can be taken as the last pixel of a byte is read.
// reset: depth 8 bpp, width 640, count 256, column 0; palette contents are
// undefined until written and need no clearing pass.
// stall: when the receiver holds i_out_ready low the output register and one
// read stage fill, then reads stop; a byte still being unpacked holds the input
// off until its last pixel is read; nothing is dropped.
`default_nettype none

module indexed_to_rgba_expand (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [itr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [itr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire itr_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output itr_pkg::t_out_item                    o_out_data
);
    import itr_pkg::*;

    // configuration registers
    t_depth_mode         r_depth_mode, n_depth_mode;
    logic [WIDTH_W-1:0]  r_image_width, n_image_width;
    logic [COUNT_W-1:0]  r_colors_count, n_colors_count;

    t_cfg                cfg;
    logic                in_fire;
    logic                pal_we;
    logic [COLOR_W-1:0]  pal_wdata;

    logic                rd_en;
    logic [PAL_AW-1:0]   rd_addr;
    t_pix_meta           rd_meta;
    logic [COLOR_W-1:0]  rd_data;
    logic                issue_ok;

    always_comb begin
        n_depth_mode   = r_depth_mode;
        n_image_width  = r_image_width;
        n_colors_count = r_colors_count;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEPTH_MODE:   n_depth_mode   = t_depth_mode'(i_cfg_data[1:0]);
                CFG_IMAGE_WIDTH:  n_image_width  = i_cfg_data[WIDTH_W-1:0];
                CFG_COLORS_COUNT: n_colors_count = i_cfg_data[COUNT_W-1:0];
                default:          ; // unused index, write ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode   <= DEPTH_MODE_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
            r_colors_count <= COLORS_COUNT_RST;
        end else begin
            r_depth_mode   <= n_depth_mode;
            r_image_width  <= n_image_width;
            r_colors_count <= n_colors_count;
        end
    end

    // clamp width to 1..max and count to the palette size
    always_comb begin
        cfg.mode = r_depth_mode;
        priority if (r_image_width == '0) begin
            cfg.width = WIDTH_W'(1);
        end else if (r_image_width > WIDTH_W'(MAX_WIDTH)) begin
            cfg.width = WIDTH_W'(MAX_WIDTH);
        end else begin
            cfg.width = r_image_width;
        end
        cfg.count = (r_colors_count > COUNT_W'(PALETTE_DEPTH)) ?
                    COUNT_W'(PALETTE_DEPTH) : r_colors_count;
    end

    // palette write goes straight to the ram on acceptance; a pixel read issued
    // on the same edge (tail of the previous byte) still sees the old entry,
    // and reads of later bytes are issued only after the write has landed
    always_comb begin
        in_fire   = i_in_valid && o_in_ready;
        pal_we    = in_fire && (i_in_data.op == OP_PALETTE_WRITE) &&
                    ({1'b0, i_in_data.entry_index} < COUNT_W'(PALETTE_DEPTH));
        pal_wdata = {i_in_data.entry_alpha, i_in_data.entry_blue,
                     i_in_data.entry_green, i_in_data.entry_red};
    end

    itr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_in_data.entry_index[PAL_AW-1:0]),
        .i_wdata (pal_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // unpacker: one palette read per cycle unless stalled, tracks the row column
    itr_unpack u_unpack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_issue_ok (issue_ok),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_rd_meta  (rd_meta)
    );

    // read stage and output register
    itr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_meta   (rd_meta),
        .i_rd_data   (rd_data),
        .o_issue_ok  (issue_ok),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire
